// ===== design/bni_pkg.sv =====
// Shared types and constants for the bitmap neighbor intersection counter.
// Depends on nothing; imported by every module of the block.
package bni_pkg;

	localparam int WORD_BITS = 64;
	localparam int VERTEX_BITS = 10;
	localparam int LIMIT_BITS = 11;
	localparam int COUNT_BITS = 11;
	localparam int ROW_SUM_BITS = 21;
	localparam int TOTAL_BITS = 32;
	localparam int KEEP_BITS = 7;
	localparam int WCNT_BITS = 5;

	localparam logic [LIMIT_BITS-1:0] VERTEX_LIMIT_RESET = 11'd1024;
	localparam logic [ROW_SUM_BITS-1:0] ROW_SUM_MAX = 21'h1FFFFF;
	localparam logic [KEEP_BITS-1:0] KEEP_FULL = 7'd64;

	localparam logic FUNC_MARK = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [2:0] NIBBLE_ONES [16] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
		3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
	};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_QUERY,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Operands for the shared popcount unit: two row words and how many low bits count.
	typedef struct packed {
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		logic [KEEP_BITS-1:0] keep;
	} pop_req_t;

endpackage

// ===== design/bitmap_neighbor_intersection_count.sv =====
// Mark item: indices are reduced, then the word is read and written back with the bit set.
// Query: indices are reduced, then words = min(ceil(neighbor_vertex/64), WORDS_PER_ROW) word
// pairs pass, one word pair a cycle, through the store's two read ports and the shared popcount
// unit, then the count is emitted once the output register is free; a zero bound reads none.
// A row index (and a query's neighbor index) of ROWS or more is folded down by ROWS; after reset
// a clearing pass zeroes the bitmap; no item is taken meanwhile, configuration writes are.
module bitmap_neighbor_intersection_count import bni_pkg::*; #(
	parameter int ROWS = 1024,
	parameter int WORDS_PER_ROW = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [LIMIT_BITS-1:0]   cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [VERTEX_BITS-1:0]  row_vertex,
	input  logic [VERTEX_BITS-1:0]  neighbor_vertex,
	input  logic                    last_in_row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COUNT_BITS-1:0]   pair_count,
	output logic [ROW_SUM_BITS-1:0] row_sum,
	output logic                    row_done,
	output logic [TOTAL_BITS-1:0]   grand_total
);

	localparam int DEPTH = ROWS * WORDS_PER_ROW;
	localparam int AW = $clog2(DEPTH);

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr_a;
	logic [AW-1:0]        mem_raddr_b;
	logic [WORD_BITS-1:0] mem_rdata_a;
	logic [WORD_BITS-1:0] mem_rdata_b;
	pop_req_t             pop_req;
	logic [KEEP_BITS-1:0] pop_count;

	bni_bitmap_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	bni_pop_unit u_pop (
		.req(pop_req),
		.count(pop_count)
	);

	bni_seq #(
		.ROWS(ROWS),
		.WORDS_PER_ROW(WORDS_PER_ROW),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.row_vertex(row_vertex),
		.neighbor_vertex(neighbor_vertex),
		.last_in_row(last_in_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pair_count(pair_count),
		.row_sum(row_sum),
		.row_done(row_done),
		.grand_total(grand_total),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b),
		.pop_req(pop_req),
		.pop_count(pop_count)
	);

endmodule

// ===== design/bni_bitmap_mem.sv =====
// Adjacency bitmap store: one write port, two registered read ports.
// Depends on bni_pkg for the word width.
module bni_bitmap_mem import bni_pkg::*; #(
	parameter int DEPTH = 16384,
	parameter int AW = 14
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr_a,
	input  logic [AW-1:0]        raddr_b,
	output logic [WORD_BITS-1:0] rdata_a,
	output logic [WORD_BITS-1:0] rdata_b
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== design/bni_pop_unit.sv =====
// Shared popcount unit: ANDs two row words, keeps the low bits, counts ones.
// Depends on bni_pkg for pop_req_t and the nibble table.
module bni_pop_unit import bni_pkg::*; (
	input  pop_req_t             req,
	output logic [KEEP_BITS-1:0] count
);

	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] both;
	logic [2:0] nib [16];
	logic [3:0] lvl1 [8];
	logic [4:0] lvl2 [4];
	logic [5:0] lvl3 [2];

	always_comb begin
		if (req.keep[KEEP_BITS-1]) begin
			mask = '1;
		end else begin
			mask = (64'd1 << req.keep[5:0]) - 64'd1;
		end
		both = req.a & req.b & mask;
		for (int k = 0; k < 16; k++) begin
			nib[k] = NIBBLE_ONES[both[4*k +: 4]];
		end
		for (int k = 0; k < 8; k++) begin
			lvl1[k] = {1'b0, nib[2*k]} + {1'b0, nib[2*k+1]};
		end
		for (int k = 0; k < 4; k++) begin
			lvl2[k] = {1'b0, lvl1[2*k]} + {1'b0, lvl1[2*k+1]};
		end
		for (int k = 0; k < 2; k++) begin
			lvl3[k] = {1'b0, lvl2[2*k]} + {1'b0, lvl2[2*k+1]};
		end
		count = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
	end

endmodule

// ===== design/bni_seq.sv =====
// Sequencer: clearing pass, row reduction, mark read-modify-write, word-by-word
// query through the popcount unit, accumulators and output register. Uses bni_pkg.
module bni_seq import bni_pkg::*; #(
	parameter int ROWS = 1024,
	parameter int WORDS_PER_ROW = 16,
	parameter int DEPTH = 16384,
	parameter int AW = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [LIMIT_BITS-1:0]   cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [VERTEX_BITS-1:0]  row_vertex,
	input  logic [VERTEX_BITS-1:0]  neighbor_vertex,
	input  logic                    last_in_row,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COUNT_BITS-1:0]   pair_count,
	output logic [ROW_SUM_BITS-1:0] row_sum,
	output logic                    row_done,
	output logic [TOTAL_BITS-1:0]   grand_total,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output logic [WORD_BITS-1:0]    mem_wdata,
	output logic [AW-1:0]           mem_raddr_a,
	output logic [AW-1:0]           mem_raddr_b,
	input  logic [WORD_BITS-1:0]    mem_rdata_a,
	input  logic [WORD_BITS-1:0]    mem_rdata_b,
	output pop_req_t                pop_req,
	input  logic [KEEP_BITS-1:0]    pop_count
);

	state_t state_q, state_d;

	logic [AW-1:0]           clr_q;
	logic [LIMIT_BITS-1:0]   vlimit_q;
	logic [ROW_SUM_BITS-1:0] row_acc_q;
	logic [TOTAL_BITS-1:0]   total_q;
	logic                    out_valid_q;
	logic                    valid_s1;
	logic [KEEP_BITS-1:0]    keep_s1;

	logic                    func_q;
	logic                    last_q;
	logic [VERTEX_BITS-1:0]  row_q;
	logic [VERTEX_BITS-1:0]  other_q;
	logic [VERTEX_BITS-1:0]  nb_q;
	logic [WCNT_BITS-1:0]    w_q;
	logic [WCNT_BITS-1:0]    words_q;
	logic [COUNT_BITS-1:0]   count_q;

	logic [COUNT_BITS-1:0]   pair_q;
	logic [ROW_SUM_BITS-1:0] sum_out_q;
	logic                    done_out_q;
	logic [TOTAL_BITS-1:0]   total_out_q;

	logic                    accept;
	logic                    emit;
	logic                    row_hi;
	logic                    oth_hi;
	logic                    mark_ok;
	logic [LIMIT_BITS-1:0]   words_sum;
	logic [WCNT_BITS-1:0]    words_calc;
	logic [LIMIT_BITS-1:0]   remain;
	logic [KEEP_BITS-1:0]    keep_w;
	logic [ROW_SUM_BITS:0]   sum_wide;
	logic [ROW_SUM_BITS-1:0] sum_sat;

	function automatic logic [AW-1:0] word_addr(input logic [VERTEX_BITS-1:0] r,
			input logic [WCNT_BITS-1:0] w);
		return AW'(32'(r) * WORDS_PER_ROW + 32'(w));
	endfunction

	assign accept = in_valid && in_ready;

	always_comb begin
		row_hi = 32'(row_q) >= ROWS;
		oth_hi = (func_q == FUNC_QUERY) && (32'(other_q) >= ROWS);
		mark_ok = ({1'b0, nb_q} < vlimit_q) && (32'(nb_q[9:6]) < WORDS_PER_ROW);
		words_sum = {1'b0, nb_q} + 11'd63;
		words_calc = words_sum[10:6];
		if (32'(words_calc) > WORDS_PER_ROW) begin
			words_calc = WCNT_BITS'(WORDS_PER_ROW);
		end
		// bits of this word that lie below the bound, capped at a full word
		remain = {1'b0, nb_q} - {w_q, 6'd0};
		keep_w = (remain >= 11'd64) ? KEEP_FULL : remain[KEEP_BITS-1:0];
		sum_wide = {1'b0, row_acc_q} + (ROW_SUM_BITS+1)'(count_q);
		sum_sat = sum_wide[ROW_SUM_BITS] ? ROW_SUM_MAX : sum_wide[ROW_SUM_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		emit = 1'b0;
		mem_we = 1'b0;
		mem_waddr = word_addr(row_q, {1'b0, nb_q[9:6]});
		mem_wdata = mem_rdata_a | (64'd1 << nb_q[5:0]);
		mem_raddr_a = word_addr(row_q, w_q);
		mem_raddr_b = word_addr(other_q, w_q);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (!row_hi && !oth_hi) begin
					if (func_q == FUNC_MARK) begin
						state_d = mark_ok ? ST_MARK_RD : ST_IDLE;
					end else begin
						state_d = (words_calc == '0) ? ST_EMIT : ST_QUERY;
					end
				end
			end
			ST_MARK_RD: begin
				mem_raddr_a = word_addr(row_q, {1'b0, nb_q[9:6]});
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				mem_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_QUERY: begin
				if (w_q == words_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// hold the finished count until the output register frees up
				if (!out_valid_q || out_ready) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			vlimit_q <= VERTEX_LIMIT_RESET;
			row_acc_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				vlimit_q <= cfg_wdata;
			end
			valid_s1 <= (state_q == ST_QUERY);
			if (emit) begin
				row_acc_q <= last_q ? '0 : sum_sat;
				total_q <= total_q + TOTAL_BITS'(count_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			last_q <= last_in_row;
			row_q <= row_vertex;
			other_q <= neighbor_vertex;
			nb_q <= neighbor_vertex;
		end
		if (state_q == ST_REDUCE) begin
			// fold indices past the store back into range
			if (row_hi) begin
				row_q <= row_q - VERTEX_BITS'(ROWS);
			end
			if (oth_hi) begin
				other_q <= other_q - VERTEX_BITS'(ROWS);
			end
			w_q <= '0;
			words_q <= words_calc;
			count_q <= '0;
		end
		if (state_q == ST_QUERY) begin
			w_q <= w_q + 1'b1;
		end
		keep_s1 <= keep_w;
		if (valid_s1) begin
			count_q <= count_q + COUNT_BITS'(pop_count);
		end
		if (emit) begin
			pair_q <= count_q;
			sum_out_q <= sum_sat;
			done_out_q <= last_q;
			total_out_q <= total_q + TOTAL_BITS'(count_q);
		end
	end

	assign pop_req.a = mem_rdata_a;
	assign pop_req.b = mem_rdata_b;
	assign pop_req.keep = keep_s1;

	assign out_valid = out_valid_q;
	assign pair_count = pair_q;
	assign row_sum = sum_out_q;
	assign row_done = done_out_q;
	assign grand_total = total_out_q;

endmodule

// ===== design/bni_checker.sv =====
// Port-level checks for the bitmap neighbor intersection counter, bound to its top level.
// Depends on bni_pkg for field widths.
module bni_checker import bni_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [COUNT_BITS-1:0]   pair_count,
	input logic [ROW_SUM_BITS-1:0] row_sum,
	input logic                    row_done,
	input logic [TOTAL_BITS-1:0]   grand_total
);

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_count) && $stable(row_sum)
			&& $stable(row_done) && $stable(grand_total))
		else $error("result changed while stalled");

	// not ready in the cycle right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// a pair count never exceeds the widest row
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pair_count <= 11'd1024)
		else $error("pair count out of range");

	// the row sum includes this item's pair count
	a_sum_covers_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_sum >= ROW_SUM_BITS'(pair_count))
		else $error("row sum below pair count");

endmodule

bind bitmap_neighbor_intersection_count bni_checker u_bni_checker (.*);
